>>> src/wmpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpc_pkg
// Shared types and constants for the windowed min-plus path cost block.
// ----------------------------------------------------------------------------
package wmpc_pkg;

   localparam int WINDOW_MAX  = 128;
   localparam int HEIGHT_BITS = 16;
   localparam int COST_BITS   = 40;
   localparam int LIMIT_BITS  = 8;
   localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COST_BITS-1:0] COST_MAX  = {COST_BITS{1'b1}};
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(2);

   // register index, taken from paddr[2]
   localparam logic REG_JUMP_LIMIT = 1'b0;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] height;
      logic                   restart;
   } req_type;

   typedef struct packed {
      logic [COST_BITS-1:0] min_cost;
      logic                 saturated;
   } rsp_type;

   // request travelling down the cell chain
   typedef struct packed {
      logic                   active;
      logic [HEIGHT_BITS-1:0] height;
      logic [COST_BITS-1:0]   best;
      logic [CNT_BITS-1:0]    remaining;
   } tok_type;

   // one stored history entry
   typedef struct packed {
      logic [HEIGHT_BITS-1:0] height;
      logic [COST_BITS-1:0]   cost;
   } ent_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // clamp the jump limit into 1..WINDOW_MAX
   function automatic logic [CNT_BITS-1:0] clamp_limit(input logic [LIMIT_BITS-1:0] lim);
      int unsigned v;
      v = int'(lim);
      if (v < 1) v = 1;
      if (v > WINDOW_MAX) v = WINDOW_MAX;
      return CNT_BITS'(v);
   endfunction

endpackage

>>> src/wmpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpc_cell
// One history slot: holds a height and its cost, folds the passing request's
// candidate cost into its running minimum, and shifts its entry onward.
// ----------------------------------------------------------------------------
module wmpc_cell
   import wmpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  tok_type tok_in,
   output tok_type tok_out,
   input  logic    shift_en,
   input  ent_type ent_in,
   output ent_type ent_out
);

   tok_type tok_ff, tok_in_next;
   ent_type ent_ff;

   logic [HEIGHT_BITS-1:0] diff;
   logic [COST_BITS:0]     sum;
   logic [COST_BITS-1:0]   cand;

   always_comb begin
      if (tok_in.height >= ent_ff.height) begin
         diff = tok_in.height - ent_ff.height;
      end else begin
         diff = ent_ff.height - tok_in.height;
      end
      sum  = {1'b0, ent_ff.cost} + (COST_BITS + 1)'(diff);
      cand = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];

      tok_in_next = tok_in;
      if (tok_in.active && (tok_in.remaining != '0)) begin
         tok_in_next.remaining = tok_in.remaining - 1'b1;
         if (cand < tok_in.best) begin
            tok_in_next.best = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in_next.active;
      end
      tok_ff.height    <= tok_in_next.height;
      tok_ff.best      <= tok_in_next.best;
      tok_ff.remaining <= tok_in_next.remaining;
      if (shift_en) begin
         ent_ff <= ent_in;
      end
   end

   assign tok_out = tok_ff;
   assign ent_out = ent_ff;

endmodule

>>> src/windowed_min_plus_path_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_min_plus_path_cost
// k-step jump least-cost stream: one cost result per height request.
// ----------------------------------------------------------------------------
// Path: a request walks the full cell chain, one cell per cycle, whatever
//   the jump limit; its cost waits in pend_ff, then rsp_valid rises. No new
//   request is taken until the FSM is back in idle; rsp_stall can hold it.
// Reset (synchronous, active high): FSM idle, chain empty of requests,
//   fill count zero, jump_limit back to 2. Stored heights/costs are not
//   cleared; the fill count keeps them from being read before written.
// ----------------------------------------------------------------------------
module windowed_min_plus_path_cost
   import wmpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [LIMIT_BITS-1:0]  jump_limit_ff;
   logic [CNT_BITS-1:0]    filled_ff, filled_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;
   logic [COST_BITS-1:0]   pend_ff;

   logic req_accept;
   logic rsp_load;
   logic chain_exit;

   // chain wiring
   tok_type tok_start;
   tok_type tok_q [0:WINDOW_MAX-1];
   ent_type ent_q [0:WINDOW_MAX-1];
   ent_type ent_new;

   logic [CNT_BITS-1:0] k_eff;
   logic [CNT_BITS-1:0] fill_base;
   logic [CNT_BITS-1:0] span;

   // ---------------------------------------------------------------------
   // Configuration: jump_limit at byte address 0, pready tied high.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == REG_JUMP_LIMIT)) begin
         jump_limit_ff <= csr_pwdata[LIMIT_BITS-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_JUMP_LIMIT: csr_prdata = CSR_DATA_W'(jump_limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: idle -> scan (request walks the chain) -> finish
   // (hand result to output register once it is free).
   // ---------------------------------------------------------------------
   assign chain_exit = tok_q[WINDOW_MAX-1].active;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (chain_exit) state_in = ST_FINISH;
         ST_FINISH: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      req_accept = (state_ff == ST_IDLE) && req_valid;
      rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Fill count: restart clears it before the request is scanned; it
   // saturates at WINDOW_MAX.
   // ---------------------------------------------------------------------
   always_comb begin
      k_eff     = clamp_limit(jump_limit_ff);
      fill_base = req_data.restart ? '0 : filled_ff;
      span      = (fill_base < k_eff) ? fill_base : k_eff;
      filled_in = (fill_base == CNT_BITS'(WINDOW_MAX)) ? fill_base : fill_base + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (req_accept) begin
         filled_ff <= filled_in;
      end
   end

   // Request enters cell 0. An empty window gives cost zero; otherwise the
   // minimum starts at the top of the range and the first span cells fold in.
   always_comb begin
      tok_start.active    = req_accept;
      tok_start.height    = req_data.height;
      tok_start.best      = (span == '0) ? '0 : COST_MAX;
      tok_start.remaining = span;
   end

   // When the request leaves the last cell, the new entry enters the front
   // of the chain and every stored entry moves one slot older.
   always_comb begin
      ent_new.height = tok_q[WINDOW_MAX-1].height;
      ent_new.cost   = tok_q[WINDOW_MAX-1].best;
   end

   // ---------------------------------------------------------------------
   // Cell chain: cell i holds the position i+1 steps back.
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         wmpc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_in   (tok_start),
            .tok_out  (tok_q[i]),
            .shift_en (chain_exit),
            .ent_in   (ent_new),
            .ent_out  (ent_q[i])
         );
      end else begin : g_body
         wmpc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_in   (tok_q[i-1]),
            .tok_out  (tok_q[i]),
            .shift_en (chain_exit),
            .ent_in   (ent_q[i-1]),
            .ent_out  (ent_q[i])
         );
      end
   end

   // ---------------------------------------------------------------------
   // Result path: pending cost, then output register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (chain_exit) begin
         pend_ff <= tok_q[WINDOW_MAX-1].best;
      end
      if (rsp_load) begin
         rsp_data_ff.min_cost  <= pend_ff;
         rsp_data_ff.saturated <= (pend_ff == COST_MAX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
